// ----- hdl/stq_pkg.sv -----
// Shared types, codes and widths for the sorted timer queue.
package stq_pkg;

  localparam int SLOT_W    = 5;
  localparam int CFG_W     = 6;
  localparam int TIME_W    = 32;
  localparam int QID_W     = 8;
  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int KIND_W    = 2;
  localparam int SLOTS_DEF = 32;
  localparam int ADDR_MAX  = 32;
  localparam int TASK_NONE = 32;
  localparam logic [TIME_W-1:0] ALL_ONES = '1;

  localparam logic [OP_W-1:0] OP_ALLOC  = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 3'd1;
  localparam logic [OP_W-1:0] OP_BIND   = 3'd2;
  localparam logic [OP_W-1:0] OP_ARM    = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK   = 3'd4;
  localparam logic [OP_W-1:0] OP_CANCEL = 3'd5;

  localparam logic [KIND_W-1:0] KIND_ACK    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CANCEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUEUE  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_TASK   = 2'd3;

  localparam logic [1:0] ST_FREE   = 2'd0;
  localparam logic [1:0] ST_ALLOC  = 2'd1;
  localparam logic [1:0] ST_ACTIVE = 2'd2;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DEC   = 11'b00000000010,
    S_INS_A = 11'b00000000100,
    S_INS_B = 11'b00000001000,
    S_INS_1 = 11'b00000010000,
    S_INS_2 = 11'b00000100000,
    S_UNH_A = 11'b00001000000,
    S_UNH_B = 11'b00010000000,
    S_UNW   = 11'b00100000000,
    S_UNW_2 = 11'b01000000000,
    S_EXP   = 11'b10000000000
  } state_t;

  typedef enum logic [3:0] {
    CMD_LATCH,
    CMD_NONE,
    CMD_DEC,
    CMD_INS_A,
    CMD_INS_B,
    CMD_INS_1,
    CMD_INS_2,
    CMD_UNH_A,
    CMD_UNH_B,
    CMD_UNW,
    CMD_UNW_2,
    CMD_EXP
  } cmd_t;

  typedef struct packed {
    logic go_ins;
    logic go_unh;
    logic go_unw;
    logic go_exp;
    logic ins_end;
    logic unw_hit;
    logic exp_end;
  } dp_sts_t;

endpackage

// ----- hdl/stq_ctrl.sv -----
// Controller state machine that sequences list walks for the timer queue.
module stq_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  stq_pkg::dp_sts_t sts,
  output stq_pkg::cmd_t    cmd,
  output logic             busy
);
  import stq_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd       = CMD_LATCH;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd = CMD_DEC;
        priority if (sts.go_ins) state_nxt = S_INS_A;
        else if (sts.go_unh) state_nxt = S_UNH_A;
        else if (sts.go_unw) state_nxt = S_UNW;
        else if (sts.go_exp) state_nxt = S_EXP;
        else state_nxt = S_IDLE;
      end
      S_INS_A: begin
        cmd       = CMD_INS_A;
        state_nxt = sts.ins_end ? S_INS_1 : S_INS_B;
      end
      S_INS_B: begin
        cmd = CMD_INS_B;
        if (sts.ins_end) state_nxt = S_INS_1;
      end
      S_INS_1: begin
        cmd       = CMD_INS_1;
        state_nxt = S_INS_2;
      end
      S_INS_2: begin
        cmd       = CMD_INS_2;
        state_nxt = S_IDLE;
      end
      S_UNH_A: begin
        cmd       = CMD_UNH_A;
        state_nxt = S_UNH_B;
      end
      S_UNH_B: begin
        cmd       = CMD_UNH_B;
        state_nxt = S_IDLE;
      end
      S_UNW: begin
        cmd = CMD_UNW;
        if (sts.unw_hit) state_nxt = S_UNW_2;
      end
      S_UNW_2: begin
        cmd       = CMD_UNW_2;
        state_nxt = S_IDLE;
      end
      S_EXP: begin
        cmd = CMD_EXP;
        if (sts.exp_end) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- hdl/stq_dp.sv -----
// Datapath: slot memories, list registers, slot status and result register.
module stq_dp #(
  parameter int SLOTS = stq_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  stq_pkg::cmd_t                      cmd,
  output stq_pkg::dp_sts_t                   sts,
  input  logic [stq_pkg::OP_W-1:0]           in_opcode,
  input  logic [stq_pkg::SLOT_W-1:0]         in_slot,
  input  logic [stq_pkg::TIME_W-1:0]         in_delay,
  input  logic [stq_pkg::QID_W-1:0]          in_queue_id,
  input  logic signed [stq_pkg::DATA_W-1:0]  in_payload,
  input  logic                               cfg_we,
  input  logic [stq_pkg::CFG_W-1:0]          cfg_data,
  output logic                               out_valid,
  output logic [stq_pkg::KIND_W-1:0]         out_kind,
  output logic                               out_status,
  output logic [stq_pkg::SLOT_W-1:0]         out_slot,
  output logic [stq_pkg::QID_W-1:0]          out_queue,
  output logic signed [stq_pkg::DATA_W-1:0]  out_payload,
  output logic                               out_last
);
  import stq_pkg::*;

  localparam int NS = (SLOTS < ADDR_MAX) ? SLOTS : ADDR_MAX;
  localparam int AW = $clog2(NS);
  localparam logic [CFG_W-1:0] NS_LIM = CFG_W'(NS);

  logic [TIME_W-1:0] dl_mem [NS];
  logic [AW-1:0]     lk_mem [NS];
  logic [QID_W-1:0]  q_mem  [NS];
  logic [DATA_W-1:0] d_mem  [NS];
  logic [TIME_W-1:0] dl_q;
  logic [AW-1:0]     lk_q;
  logic [QID_W-1:0]  q_q;
  logic [DATA_W-1:0] d_q;
  logic              rd_zero_r;

  logic [1:0]        st_r [NS];

  logic [OP_W-1:0]   op_r;
  logic [SLOT_W-1:0] slot_r;
  logic [TIME_W-1:0] delay_r;
  logic [QID_W-1:0]  qid_r;
  logic [DATA_W-1:0] pay_r;
  logic [TIME_W-1:0] darm_r, darm_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [TIME_W-1:0] tick_r, tick_nxt;
  logic [TIME_W-1:0] earl_r, earl_nxt;
  logic [CFG_W-1:0]  task_r;
  logic [AW-1:0]     prev_r, prev_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic              pend_v_r, pend_v_nxt;
  logic [AW-1:0]     pend_slot_r, pend_slot_nxt;
  logic [QID_W-1:0]  pend_q_r, pend_q_nxt;
  logic [DATA_W-1:0] pend_d_r, pend_d_nxt;

  logic [AW-1:0]     raddr;
  logic              dl_we, lk_we, qd_we, st_we;
  logic [AW-1:0]     lk_wa, st_wa;
  logic [AW-1:0]     lk_wd;
  logic [1:0]        st_wd;

  logic              em_v, em_st, em_last;
  logic [KIND_W-1:0] em_kind;
  logic [SLOT_W-1:0] em_slot;
  logic [QID_W-1:0]  em_q;
  logic [DATA_W-1:0] em_d;

  logic              ff_found;
  logic [AW-1:0]     ff_idx;
  logic [AW-1:0]     sa;
  logic              s_ok;
  logic [1:0]        st_s;
  logic [TIME_W-1:0] dl_new, tick_inc, dl_eff;
  logic              exp_go;

  assign sa       = slot_r[AW-1:0];
  assign s_ok     = {1'b0, slot_r} < NS_LIM;
  assign st_s     = st_r[sa];
  assign dl_new   = delay_r + tick_r;
  assign tick_inc = tick_r + TIME_W'(1);
  assign dl_eff   = rd_zero_r ? ALL_ONES : dl_q;
  assign exp_go   = (head_r != '0) && (dl_eff <= tick_r);

  // lowest free slot wins
  always_comb begin
    ff_found = 1'b0;
    ff_idx   = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (st_r[i] == ST_FREE) begin
        ff_found = 1'b1;
        ff_idx   = AW'(i);
      end
    end
  end

  always_comb begin
    sts           = '0;
    raddr         = head_r;
    dl_we         = 1'b0;
    lk_we         = 1'b0;
    qd_we         = 1'b0;
    st_we         = 1'b0;
    lk_wa         = sa;
    lk_wd         = head_r;
    st_wa         = sa;
    st_wd         = ST_ALLOC;
    darm_nxt      = darm_r;
    head_nxt      = head_r;
    tick_nxt      = tick_r;
    earl_nxt      = earl_r;
    prev_nxt      = prev_r;
    cur_nxt       = cur_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    pend_q_nxt    = pend_q_r;
    pend_d_nxt    = pend_d_r;
    em_v          = 1'b0;
    em_kind       = KIND_ACK;
    em_st         = 1'b0;
    em_slot       = slot_r;
    em_q          = '0;
    em_d          = '0;
    em_last       = 1'b1;
    unique case (cmd)
      CMD_LATCH, CMD_NONE: begin
      end
      CMD_DEC: begin
        unique case (op_r)
          OP_ALLOC: begin
            em_v    = 1'b1;
            em_st   = !ff_found;
            em_slot = ff_found ? SLOT_W'(ff_idx) : '0;
            st_we   = ff_found;
            st_wa   = ff_idx;
          end
          OP_FREE: begin
            em_v  = 1'b1;
            em_st = !s_ok || (st_s == ST_ACTIVE);
            st_we = !em_st;
            st_wd = ST_FREE;
          end
          OP_BIND: begin
            em_v  = 1'b1;
            em_st = !s_ok;
            qd_we = s_ok;
          end
          OP_ARM: begin
            if (!s_ok || (st_s == ST_ACTIVE)) begin
              em_v  = 1'b1;
              em_st = 1'b1;
            end else begin
              dl_we    = 1'b1;
              st_we    = 1'b1;
              st_wd    = ST_ACTIVE;
              darm_nxt = dl_new;
              if (dl_new <= earl_r) begin
                lk_we    = 1'b1;
                head_nxt = sa;
                earl_nxt = dl_new;
                em_v     = 1'b1;
              end else begin
                sts.go_ins = 1'b1;
                prev_nxt   = head_r;
              end
            end
          end
          OP_TICK: begin
            tick_nxt   = tick_inc;
            pend_v_nxt = 1'b0;
            sts.go_exp = (earl_r <= tick_inc);
          end
          OP_CANCEL: begin
            if (!s_ok || (slot_r == '0) || (st_s != ST_ACTIVE)) begin
              em_v    = 1'b1;
              em_kind = KIND_CANCEL;
              em_st   = 1'b1;
            end else if (sa == head_r) begin
              sts.go_unh = 1'b1;
              raddr      = sa;
            end else begin
              sts.go_unw = 1'b1;
              cur_nxt    = head_r;
            end
          end
          default: begin
            em_v    = 1'b1;
            em_st   = 1'b1;
            em_slot = '0;
          end
        endcase
      end
      CMD_INS_A: begin
        cur_nxt     = lk_q;
        raddr       = lk_q;
        sts.ins_end = (lk_q == '0);
      end
      CMD_INS_B: begin
        raddr = lk_q;
        if (darm_r <= dl_eff) begin
          sts.ins_end = 1'b1;
        end else begin
          prev_nxt    = cur_r;
          cur_nxt     = lk_q;
          sts.ins_end = (lk_q == '0);
        end
      end
      CMD_INS_1: begin
        lk_we = 1'b1;
        lk_wd = cur_r;
      end
      CMD_INS_2: begin
        lk_we = 1'b1;
        lk_wa = prev_r;
        lk_wd = sa;
        em_v  = 1'b1;
      end
      CMD_UNH_A: begin
        head_nxt = lk_q;
        raddr    = lk_q;
      end
      CMD_UNH_B: begin
        earl_nxt = dl_eff;
        st_we    = 1'b1;
        em_v     = 1'b1;
        em_kind  = KIND_CANCEL;
      end
      CMD_UNW: begin
        if (lk_q == sa) begin
          sts.unw_hit = 1'b1;
          raddr       = sa;
        end else begin
          cur_nxt = lk_q;
          raddr   = lk_q;
        end
      end
      CMD_UNW_2: begin
        lk_we   = 1'b1;
        lk_wa   = cur_r;
        lk_wd   = lk_q;
        st_we   = 1'b1;
        em_v    = 1'b1;
        em_kind = KIND_CANCEL;
      end
      CMD_EXP: begin
        // hold each expiry in the pending registers so its last flag is known
        if (pend_v_r) begin
          em_v    = 1'b1;
          em_slot = SLOT_W'(pend_slot_r);
          em_last = !exp_go;
          if ({1'b0, SLOT_W'(pend_slot_r)} == task_r) begin
            em_kind = KIND_TASK;
          end else begin
            em_kind = KIND_QUEUE;
            em_q    = pend_q_r;
            em_d    = pend_d_r;
          end
        end
        if (exp_go) begin
          st_we         = 1'b1;
          st_wa         = head_r;
          pend_v_nxt    = 1'b1;
          pend_slot_nxt = head_r;
          pend_q_nxt    = q_q;
          pend_d_nxt    = d_q;
          head_nxt      = lk_q;
          raddr         = lk_q;
        end else begin
          earl_nxt    = dl_eff;
          pend_v_nxt  = 1'b0;
          sts.exp_end = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    dl_q      <= dl_mem[raddr];
    lk_q      <= lk_mem[raddr];
    q_q       <= q_mem[raddr];
    d_q       <= d_mem[raddr];
    rd_zero_r <= (raddr == '0);
    if (dl_we) dl_mem[sa] <= dl_new;
    if (lk_we) lk_mem[lk_wa] <= lk_wd;
    if (qd_we) begin
      q_mem[sa] <= qid_r;
      d_mem[sa] <= pay_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == CMD_LATCH) begin
      op_r    <= in_opcode;
      slot_r  <= in_slot;
      delay_r <= in_delay;
      qid_r   <= in_queue_id;
      pay_r   <= DATA_W'(in_payload);
    end
    darm_r      <= darm_nxt;
    prev_r      <= prev_nxt;
    cur_r       <= cur_nxt;
    pend_slot_r <= pend_slot_nxt;
    pend_q_r    <= pend_q_nxt;
    pend_d_r    <= pend_d_nxt;
    out_kind    <= em_kind;
    out_status  <= em_st;
    out_slot    <= em_slot;
    out_queue   <= em_q;
    out_payload <= signed'(em_d);
    out_last    <= em_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      tick_r    <= '0;
      earl_r    <= ALL_ONES;
      task_r    <= CFG_W'(TASK_NONE);
      pend_v_r  <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < NS; i++) begin
        st_r[i] <= (i == 0) ? ST_ACTIVE : ST_FREE;
      end
    end else begin
      head_r    <= head_nxt;
      tick_r    <= tick_nxt;
      earl_r    <= earl_nxt;
      pend_v_r  <= pend_v_nxt;
      out_valid <= em_v;
      if (cfg_we) task_r <= cfg_data;
      if (st_we) st_r[st_wa] <= st_wd;
    end
  end

endmodule

// ----- hdl/sorted_timer_queue.sv -----
// Top level of the sorted timer queue: controller, datapath and checks.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+----------------------------------------
//  input    | start / busy               | in_opcode in_slot in_delay in_queue_id
//           |                            | in_payload
//  result   | out_valid (one cycle)      | out_kind out_status out_slot out_queue
//           |                            | out_payload out_last
//  config   | cfg_we                     | cfg_data (task slot)
//
// Simple requests are answered from the decode state. Arm and cancel walk the
// linked list through the slot memories; a tick gives one strobe per expired slot.
// The slot memories have a single registered read port.
// Reset is synchronous and needs no clearing pass. Results cannot be stalled.
module sorted_timer_queue #(
  parameter int SLOTS = stq_pkg::SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [stq_pkg::OP_W-1:0]           in_opcode,
  input  logic [stq_pkg::SLOT_W-1:0]         in_slot,
  input  logic [stq_pkg::TIME_W-1:0]         in_delay,
  input  logic [stq_pkg::QID_W-1:0]          in_queue_id,
  input  logic signed [stq_pkg::DATA_W-1:0]  in_payload,
  input  logic                               cfg_we,
  input  logic [stq_pkg::CFG_W-1:0]          cfg_data,
  output logic                               out_valid,
  output logic [stq_pkg::KIND_W-1:0]         out_kind,
  output logic                               out_status,
  output logic [stq_pkg::SLOT_W-1:0]         out_slot,
  output logic [stq_pkg::QID_W-1:0]          out_queue,
  output logic signed [stq_pkg::DATA_W-1:0]  out_payload,
  output logic                               out_last
);
  import stq_pkg::*;

  cmd_t    cmd;
  dp_sts_t sts;

  stq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  stq_dp #(.SLOTS(SLOTS)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_opcode   (in_opcode),
    .in_slot     (in_slot),
    .in_delay    (in_delay),
    .in_queue_id (in_queue_id),
    .in_payload  (in_payload),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_kind    (out_kind),
    .out_status  (out_status),
    .out_slot    (out_slot),
    .out_queue   (out_queue),
    .out_payload (out_payload),
    .out_last    (out_last)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_ACK || out_kind == KIND_CANCEL)) |-> out_last)
    else $error("request result not marked last");

  a_task_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == KIND_TASK) |-> (out_queue == '0 && out_payload == '0))
    else $error("task switch expiry carries data");

  a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_QUEUE || out_kind == KIND_TASK))
      |-> (!out_status && out_slot != '0))
    else $error("expiry with error status or sentinel slot");

endmodule
